// ===== sv/ldfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LoRaWAN data frame parser package
// Shared types and constants for the frame parser and uplink filter.
// ----------------------------------------------------------------------------
package ldfp_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PORT_FILTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_PREFIX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BITS = 2'd2;

  localparam logic [5:0] PREFIX_BITS_RESET = 6'd32;
  localparam logic [5:0] PREFIX_BITS_FULL  = 6'd32;

  localparam logic [2:0] MTYPE_UNCONF_UP = 3'd2;
  localparam logic [2:0] MTYPE_CONF_UP   = 3'd4;

  localparam logic [1:0] VERDICT_PASS      = 2'd0;
  localparam logic [1:0] VERDICT_PORT_MISS = 2'd1;
  localparam logic [1:0] VERDICT_ADDR_MISS = 2'd2;

  localparam logic [3:0] OPTS_MASK = 4'hF;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  mac_header;
    logic [31:0] device_address;
    logic [7:0]  frame_control;
    logic [15:0] frame_counter;
    logic [7:0]  port_number;
    logic [31:0] integrity_code;
    logic [1:0]  filter_verdict;
    logic        frame_short;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  header;
    logic [31:0] address;
    logic [7:0]  control;
    logic [15:0] counter;
    logic [7:0]  port;
    logic [31:0] mic;
    logic        short_frame;
  } frame_rec_t;

  typedef struct packed {
    logic [7:0]  port_filter;
    logic [31:0] addr_prefix;
    logic [5:0]  prefix_bits;
  } cfg_t;

endpackage

// ===== sv/ldfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LoRaWAN frame parser front end
// Captures header fields byte by byte and emits a frame record at frame end.
// ----------------------------------------------------------------------------
module ldfp_front #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  ldfp_pkg::in_item_t  item,
  output logic                push,
  output ldfp_pkg::frame_rec_t rec
);

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_BYTES);

  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       header_store, header_store_next;
  logic [31:0]      address_store, address_store_next;
  logic [7:0]       control_store, control_store_next;
  logic [15:0]      counter_store, counter_store_next;
  logic [7:0]       port_candidate, port_candidate_next;
  logic [31:0]      tail_bytes, tail_bytes_next;
  logic [3:0]       opts;
  logic [7:0]       b;

  always_comb begin
    b                   = item.frame_byte;
    header_store_next   = header_store;
    address_store_next  = address_store;
    control_store_next  = control_store;
    counter_store_next  = counter_store;
    port_candidate_next = port_candidate;
    opts                = control_store[3:0] & ldfp_pkg::OPTS_MASK;
    case (byte_index)
      IDX_W'(0): header_store_next = b;
      IDX_W'(1): address_store_next[7:0] = b;
      IDX_W'(2): address_store_next[15:8] = b;
      IDX_W'(3): address_store_next[23:16] = b;
      IDX_W'(4): address_store_next[31:24] = b;
      IDX_W'(5): begin
        control_store_next = b;
        opts               = b[3:0] & ldfp_pkg::OPTS_MASK;
      end
      IDX_W'(6): counter_store_next = {8'd0, b};
      IDX_W'(7): counter_store_next[15:8] = b;
      default: ;
    endcase
    if (byte_index == IDX_W'(8) + IDX_W'(opts)) begin
      port_candidate_next = b;
    end
    tail_bytes_next = {b, tail_bytes[31:8]};
    byte_index_next = (byte_index < IDX_MAX) ? byte_index + IDX_W'(1) : byte_index;

    rec.header      = header_store_next;
    rec.address     = address_store_next;
    rec.control     = control_store_next;
    rec.counter     = counter_store_next;
    rec.port        = (byte_index_next >= IDX_W'(13) + IDX_W'(opts)) ?
                      port_candidate_next : 8'd0;
    rec.mic         = tail_bytes_next;
    rec.short_frame = byte_index_next < IDX_W'(12) + IDX_W'(opts);
    push            = accept && item.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_index     <= '0;
      header_store   <= '0;
      address_store  <= '0;
      control_store  <= '0;
      counter_store  <= '0;
      port_candidate <= '0;
      tail_bytes     <= '0;
    end else if (accept) begin
      byte_index     <= byte_index_next;
      header_store   <= header_store_next;
      address_store  <= address_store_next;
      control_store  <= control_store_next;
      counter_store  <= counter_store_next;
      port_candidate <= port_candidate_next;
      tail_bytes     <= tail_bytes_next;
    end
  end

endmodule

// ===== sv/ldfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LoRaWAN frame record queue
// Two-entry queue of frame records between the front and back ends.
// ----------------------------------------------------------------------------
module ldfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ldfp_pkg::frame_rec_t wr_rec,
  output logic                 full,
  input  logic                 pop_req,
  output logic                 avail,
  output ldfp_pkg::frame_rec_t rd_rec
);

  ldfp_pkg::frame_rec_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop    = pop_req && (count != 2'd0);
  assign full   = (count == 2'd2);
  assign avail  = (count != 2'd0);
  assign rd_rec = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/ldfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LoRaWAN frame filter back end
// Applies the uplink port and address filter and holds the result register.
// ----------------------------------------------------------------------------
module ldfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ldfp_pkg::cfg_t       cfg,
  input  logic                 q_avail,
  output logic                 q_pop,
  input  ldfp_pkg::frame_rec_t rec,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ldfp_pkg::out_item_t  out_data
);

  logic        take;
  logic [2:0]  mtype;
  logic [31:0] prefix;
  logic [5:0]  shift;
  logic [1:0]  verdict;

  assign take  = q_avail && (!out_valid || !out_stall);
  assign q_pop = take;

  always_comb begin
    shift = ldfp_pkg::PREFIX_BITS_FULL - cfg.prefix_bits;
    if (cfg.prefix_bits == 6'd0) begin
      prefix = 32'd0;
    end else if (cfg.prefix_bits >= ldfp_pkg::PREFIX_BITS_FULL) begin
      prefix = rec.address;
    end else begin
      prefix = rec.address >> shift[4:0];
    end
    mtype   = rec.header[7:5];
    verdict = ldfp_pkg::VERDICT_PASS;
    if (mtype == ldfp_pkg::MTYPE_UNCONF_UP || mtype == ldfp_pkg::MTYPE_CONF_UP) begin
      if (cfg.port_filter != 8'd0 && rec.port != cfg.port_filter) begin
        verdict = ldfp_pkg::VERDICT_PORT_MISS;
      end else if (cfg.addr_prefix != 32'd0 && prefix != cfg.addr_prefix) begin
        verdict = ldfp_pkg::VERDICT_ADDR_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.mac_header     <= rec.header;
      out_data.device_address <= rec.address;
      out_data.frame_control  <= rec.control;
      out_data.frame_counter  <= rec.counter;
      out_data.port_number    <= rec.port;
      out_data.integrity_code <= rec.mic;
      out_data.filter_verdict <= verdict;
      out_data.frame_short    <= rec.short_frame;
    end
  end

endmodule

// ===== sv/lorawan_data_frame_parser_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LoRaWAN data frame parser and uplink filter
// Parses MAC header fields of a data frame one byte per transaction.
//
// Input channel: one frame byte per transaction, frame_end on the last byte.
// Output channel: one result per frame with MHDR, DevAddr, FCtrl, FCnt, FPort,
// MIC, a short-frame flag and the filter verdict.
// Throughput: one byte per cycle while the input is not stalled. A frame's
// result passes through a queue entry and then the back-end result register
// after its last byte is accepted.
// Config: a write port for port_filter, addr_prefix and prefix_bits; write
// only while the block is idle.
// Reset clears the per-frame capture state, the queue, the output register
// and the configuration (prefix_bits returns to 32).
// When the receiver stalls, the result holds; the two-entry queue takes
// further finished frames and the input stalls only once it is full.
// ----------------------------------------------------------------------------
module lorawan_data_frame_parser_filter_unit #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ldfp_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ldfp_pkg::out_item_t                 out_data,
  input  logic                                cfg_write_en,
  input  logic [ldfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ldfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ldfp_pkg::cfg_t       cfg;
  ldfp_pkg::frame_rec_t wr_rec, rd_rec;
  logic                 q_avail, q_pop;
  logic                 accept, push, full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port_filter <= 8'd0;
      cfg.addr_prefix <= 32'd0;
      cfg.prefix_bits <= ldfp_pkg::PREFIX_BITS_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        ldfp_pkg::CFG_PORT_FILTER: cfg.port_filter <= cfg_data[7:0];
        ldfp_pkg::CFG_ADDR_PREFIX: cfg.addr_prefix <= cfg_data[31:0];
        ldfp_pkg::CFG_PREFIX_BITS: cfg.prefix_bits <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  ldfp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (in_data),
    .push  (push),
    .rec   (wr_rec)
  );

  ldfp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .full   (full),
    .pop_req(q_pop),
    .avail  (q_avail),
    .rd_rec (rd_rec)
  );

  ldfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_avail  (q_avail),
    .q_pop    (q_pop),
    .rec      (rd_rec),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.filter_verdict == ldfp_pkg::VERDICT_PASS ||
                   out_data.filter_verdict == ldfp_pkg::VERDICT_PORT_MISS ||
                   out_data.filter_verdict == ldfp_pkg::VERDICT_ADDR_MISS))
    else $error("undefined filter verdict");

  a_downlink_passes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.mac_header[7:5] != ldfp_pkg::MTYPE_UNCONF_UP &&
     out_data.mac_header[7:5] != ldfp_pkg::MTYPE_CONF_UP)
    |-> out_data.filter_verdict == ldfp_pkg::VERDICT_PASS)
    else $error("non-uplink frame filtered");

  a_port_implies_long: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.port_number != 8'd0) |-> !out_data.frame_short)
    else $error("port reported on short frame");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LoRaWAN data frame parser testbench
// Feeds frame bytes through the parser: a few hand-built frames, then random
// well-formed, truncated, oversized and garbage frames under several filter
// settings. A cycle-accurate-free predictor tracks the MAC header fields, FPort,
// MIC, short flag and filter verdict of each frame, and a monitor compares
// every result transaction against the oldest predicted one. Sender gaps,
// receiver stalls and one long receiver hold-off exercise the back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int PHASES          = 8;
  localparam int PHASE_BYTES     = 105;
  localparam int QUIET_LIMIT     = 5000;
  localparam int LONG_HOLD       = 300;

  localparam int SHAPE_GOOD  = 0;
  localparam int SHAPE_CUT   = 1;
  localparam int SHAPE_NOISE = 2;
  localparam int SHAPE_LONG  = 3;

  logic                            clk;
  logic                            rst          = 1'b1;
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  ldfp_pkg::in_item_t              in_data      = '0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  ldfp_pkg::out_item_t             out_data;
  logic                            cfg_write_en = 1'b0;
  logic [ldfp_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [ldfp_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

  lorawan_data_frame_parser_filter_unit #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // filter settings as last written
  logic [7:0]  flt_port   = 8'h00;
  logic [31:0] flt_prefix = 32'h0;
  logic [5:0]  flt_bits   = ldfp_pkg::PREFIX_BITS_RESET;

  // per-frame capture state of the predictor
  int unsigned pos_cnt  = 0;
  logic [7:0]  hdr_acc  = 8'h00;
  logic [31:0] dev_acc  = 32'h0;
  logic [7:0]  ctl_acc  = 8'h00;
  logic [15:0] cnt_acc  = 16'h0;
  logic [7:0]  port_acc = 8'h00;
  logic [31:0] tail_acc = 32'h0;

  ldfp_pkg::out_item_t expected_frames[$];
  ldfp_pkg::in_item_t  byte_queue[$];
  logic [7:0]          frame_buf[$];
  int unsigned queued_total = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  int burst_left = 1;
  int gap_left   = 0;

  bit long_hold_req = 1'b0;
  int hold_left     = 0;
  int stall_mode    = 0;
  int mode_left     = 0;
  int unsigned rx_cyc = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] addr_top(input logic [31:0] a, input logic [5:0] n);
    if (n == 0) return 32'h0;
    if (n >= 32) return a;
    return a >> (32 - n);
  endfunction

  function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
    if ($urandom_range(0, 1) == 1) return v | ($urandom() << w);
    return v;
  endfunction

  task automatic parse_byte(input ldfp_pkg::in_item_t it);
    logic [7:0]          b;
    int unsigned         pos;
    int unsigned         opts;
    int unsigned         len;
    logic [7:0]          port;
    logic [1:0]          verdict;
    ldfp_pkg::out_item_t r;
    b    = it.frame_byte;
    pos  = pos_cnt;
    opts = 32'(ctl_acc[3:0]);
    if (pos == 0) begin
      hdr_acc = b;
    end else if (pos <= 4) begin
      dev_acc = dev_acc | ({24'h0, b} << (8 * (pos - 1)));
    end else if (pos == 5) begin
      ctl_acc = b;
      opts    = 32'(b[3:0]);
    end else if (pos == 6) begin
      cnt_acc = {8'h00, b};
    end else if (pos == 7) begin
      cnt_acc[15:8] = b;
    end
    if (pos >= 8 && pos == 8 + opts) port_acc = b;
    tail_acc = {b, tail_acc[31:8]};
    if (pos_cnt < MAX_FRAME_BYTES) pos_cnt++;
    if (it.frame_end) begin
      len     = pos_cnt;
      port    = (len >= 13 + opts) ? port_acc : 8'h00;
      verdict = ldfp_pkg::VERDICT_PASS;
      if (hdr_acc[7:5] == ldfp_pkg::MTYPE_UNCONF_UP ||
          hdr_acc[7:5] == ldfp_pkg::MTYPE_CONF_UP) begin
        if (flt_port != 8'h00 && port != flt_port) begin
          verdict = ldfp_pkg::VERDICT_PORT_MISS;
        end else if (flt_prefix != 32'h0 && addr_top(dev_acc, flt_bits) != flt_prefix) begin
          verdict = ldfp_pkg::VERDICT_ADDR_MISS;
        end
      end
      r.mac_header     = hdr_acc;
      r.device_address = dev_acc;
      r.frame_control  = ctl_acc;
      r.frame_counter  = cnt_acc;
      r.port_number    = port;
      r.integrity_code = tail_acc;
      r.filter_verdict = verdict;
      r.frame_short    = (len < 12 + opts);
      expected_frames.push_back(r);
      pos_cnt  = 0;
      hdr_acc  = 8'h00;
      dev_acc  = 32'h0;
      ctl_acc  = 8'h00;
      cnt_acc  = 16'h0;
      port_acc = 8'h00;
      tail_acc = 32'h0;
    end
  endtask

  task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input ldfp_pkg::out_item_t got);
    ldfp_pkg::out_item_t want;
    if (expected_frames.size() == 0) begin
      mismatches++;
      $display("%0t: result with no frame pending, expected none actual %h", $time, got);
    end else begin
      want = expected_frames.pop_front();
      field_check("mac_header", 32'(want.mac_header), 32'(got.mac_header));
      field_check("device_address", want.device_address, got.device_address);
      field_check("frame_control", 32'(want.frame_control), 32'(got.frame_control));
      field_check("frame_counter", 32'(want.frame_counter), 32'(got.frame_counter));
      field_check("port_number", 32'(want.port_number), 32'(got.port_number));
      field_check("integrity_code", want.integrity_code, got.integrity_code);
      field_check("filter_verdict", 32'(want.filter_verdict), 32'(got.filter_verdict));
      field_check("frame_short", 32'(want.frame_short), 32'(got.frame_short));
    end
  endtask

  // monitor, predictor feed and watchdog
  always @(posedge clk) begin
    in_taken  = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
    if (out_taken) check_result(out_data);
    if (in_taken) parse_byte(in_data);
    if (in_taken || out_taken || cfg_write_en) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sender: bursts of bytes with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_data  <= byte_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern, plus one long hold-off on request
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (rx_cyc % 3 == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [ldfp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      ldfp_pkg::CFG_PORT_FILTER: flt_port   = val[7:0];
      ldfp_pkg::CFG_ADDR_PREFIX: flt_prefix = val;
      ldfp_pkg::CFG_PREFIX_BITS: flt_bits   = val[5:0];
      default: ;
    endcase
  endtask

  task automatic flush_frame(input bit random_ends);
    ldfp_pkg::in_item_t it;
    while (frame_buf.size() != 0) begin
      it.frame_byte = frame_buf.pop_front();
      it.frame_end  = (frame_buf.size() == 0) ||
                      (random_ends && $urandom_range(0, 3) == 0);
      byte_queue.push_back(it);
      queued_total++;
    end
  endtask

  task automatic queue_frame(input int shape);
    logic [31:0] dev;
    logic [7:0]  ctrl;
    logic [2:0]  mt;
    int unsigned pick;
    int unsigned payload;
    int unsigned cut;
    frame_buf = {};
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 8)) frame_buf.push_back(rand_byte());
    end else begin
      pick = $urandom_range(0, 9);
      mt   = (pick < 4) ? ldfp_pkg::MTYPE_UNCONF_UP :
             (pick < 7) ? ldfp_pkg::MTYPE_CONF_UP : 3'($urandom_range(0, 7));
      frame_buf.push_back({mt, 5'($urandom_range(0, 31))});
      dev = $urandom();
      if ($urandom_range(0, 1) == 1) begin
        if (flt_bits >= 32) dev = flt_prefix;
        else if (flt_bits != 0)
          dev = (flt_prefix << (32 - flt_bits)) | (dev & (32'hFFFF_FFFF >> flt_bits));
      end
      for (int i = 0; i < 4; i++) frame_buf.push_back(dev[8*i +: 8]);
      ctrl = rand_byte();
      if ($urandom_range(0, 1) == 0) ctrl[3:0] = 4'h0;
      frame_buf.push_back(ctrl);
      repeat (2 + ctrl[3:0]) frame_buf.push_back(rand_byte());
      payload = (shape == SHAPE_LONG) ? $urandom_range(250, 300) : $urandom_range(0, 12);
      if (shape == SHAPE_LONG || $urandom_range(0, 3) != 0) begin
        frame_buf.push_back(($urandom_range(0, 1) == 1) ? flt_port : rand_byte());
        repeat (payload) frame_buf.push_back(rand_byte());
      end
      repeat (4) frame_buf.push_back(rand_byte());
      if (shape == SHAPE_CUT) begin
        cut = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
    end
    flush_frame(shape == SHAPE_NOISE);
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input int phase);
    int unsigned n;
    logic [31:0] pv;
    case (phase)
      0: begin
        write_reg(ldfp_pkg::CFG_PORT_FILTER, with_junk(32'h0, 8));
        write_reg(ldfp_pkg::CFG_ADDR_PREFIX, 32'h0);
        write_reg(ldfp_pkg::CFG_PREFIX_BITS, with_junk(32'd32, 6));
      end
      1: begin
        write_reg(ldfp_pkg::CFG_PORT_FILTER, with_junk(32'hFF, 8));
        write_reg(ldfp_pkg::CFG_ADDR_PREFIX, 32'hFFFF_FFFF);
        write_reg(ldfp_pkg::CFG_PREFIX_BITS, with_junk(32'd32, 6));
      end
      2, 3: begin
        n  = (phase == 2) ? $urandom_range(1, 31) : 8;
        pv = $urandom() & (32'hFFFF_FFFF >> (32 - n));
        if (pv == 0) pv = 32'h1;
        write_reg(ldfp_pkg::CFG_PORT_FILTER,
                  with_junk((phase == 2) ? $urandom_range(1, 254) : 0, 8));
        write_reg(ldfp_pkg::CFG_ADDR_PREFIX, pv);
        write_reg(ldfp_pkg::CFG_PREFIX_BITS, with_junk(n, 6));
      end
      4: begin
        write_reg(ldfp_pkg::CFG_PORT_FILTER, with_junk($urandom_range(0, 255), 8));
        write_reg(ldfp_pkg::CFG_ADDR_PREFIX, 32'h1);
        write_reg(ldfp_pkg::CFG_PREFIX_BITS, with_junk(32'd1, 6));
      end
      5: begin
        write_reg(ldfp_pkg::CFG_PORT_FILTER, 32'h0);
        write_reg(ldfp_pkg::CFG_ADDR_PREFIX, $urandom() | 32'h1);
        write_reg(ldfp_pkg::CFG_PREFIX_BITS, with_junk(32'd0, 6));
      end
      6: begin
        write_reg(ldfp_pkg::CFG_PORT_FILTER, with_junk($urandom_range(0, 255), 8));
        write_reg(ldfp_pkg::CFG_ADDR_PREFIX, $urandom());
        write_reg(ldfp_pkg::CFG_PREFIX_BITS, with_junk($urandom_range(33, 63), 6));
      end
      default: begin
        write_reg(ldfp_pkg::CFG_PORT_FILTER, with_junk($urandom_range(1, 255), 8));
        write_reg(ldfp_pkg::CFG_ADDR_PREFIX, 32'h0);
        write_reg(ldfp_pkg::CFG_PREFIX_BITS, with_junk(32'd16, 6));
      end
    endcase
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // frames of one to three bytes: header and MIC mostly missing
    frame_buf = {8'h00};
    flush_frame(1'b0);
    frame_buf = {8'hFF};
    flush_frame(1'b0);
    frame_buf = {8'hFF, 8'hFF, 8'hFF};
    flush_frame(1'b0);
    // all-ones header, full options length, too short
    repeat (8) frame_buf.push_back(8'hFF);
    flush_frame(1'b0);
    // minimal uplink with a port
    frame_buf = {8'h40, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h34, 8'h12,
                 8'h0A, 8'hAA, 8'hBB, 8'hCC, 8'hDD};
    flush_frame(1'b0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      apply_settings(p);
      if (p == 3) long_hold_req = 1'b1;
      if (p == 4 || p == 6) queue_frame(SHAPE_LONG);
      while (queued_total < 26 + (p + 1) * PHASE_BYTES) begin
        case ($urandom_range(0, 9))
          7, 8: queue_frame(SHAPE_CUT);
          9: queue_frame(SHAPE_NOISE);
          default: queue_frame(SHAPE_GOOD);
        endcase
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== lorawan_data_frame_parser_filter_unit.f =====
sv/ldfp_pkg.sv
sv/ldfp_front.sv
sv/ldfp_queue.sv
sv/ldfp_back.sv
sv/lorawan_data_frame_parser_filter_unit.sv
test/tb_top.sv
